// ===== hdl/bcd_alu_pkg.sv =====
// package: opcodes, widths and digit helpers for the decimal alu
package bcd_alu_pkg;
	localparam int NUM_DIGITS_DEF = 16;
	localparam int OP_W = 3;
	localparam int WORD_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} opcode_t;

	// one-digit decimal add with carry in, 5 bit sum -> digit and carry
	function automatic logic [4:0] dec_add(input logic [3:0] x, input logic [3:0] y,
		input logic ci);
		logic [4:0] s;
		begin
			s = {1'b0, x} + {1'b0, y} + {4'd0, ci};
			if (s > 5'd9)
				dec_add = {1'b1, 4'(s - 5'd10)};
			else
				dec_add = {1'b0, s[3:0]};
		end
	endfunction

	// nine's complement of a digit
	function automatic logic [3:0] dec_nines(input logic [3:0] x);
		dec_nines = 4'd9 - x;
	endfunction
endpackage

// ===== hdl/bcd_fixed_width_alu.sv =====
// top level: decimal alu with valid/stall channels
//  channel | signals                                     | dir
//  in      | in_valid in_stall opcode operand_a operand_b | sink
//  out     | out_valid out_stall value_out flags          | source
// one beat at a time; add, subtract, multiply and divide run digit-serially
// in the core through the single digit adder the sequencer shares, while
// compare, unknown opcodes and errors skip the core and are registered out.
// reset clears control only; the result register holds under out_stall
// and the next beat is taken once the result leaves.
module bcd_fixed_width_alu #(
	parameter int NUM_DIGITS = bcd_alu_pkg::NUM_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value_out,
	output logic        a_less,
	output logic        a_equal,
	output logic        a_greater,
	output logic        error_flag
);
	localparam int W = 4*NUM_DIGITS;

	logic busy_q, wait_q, start;
	logic [W-1:0] ma, mb, res;
	logic bad, done;
	logic err_q;

	assign ma = operand_a[W-1:0];
	assign mb = operand_b[W-1:0];

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < NUM_DIGITS; i++)
			bad = bad | (ma[4*i +: 4] > 4'd9) | (mb[4*i +: 4] > 4'd9);
	end

	assign in_stall = busy_q | out_valid;
	assign start = in_valid & ~in_stall;

	logic cstart;
	assign cstart = start & ~bad & (opcode == bcd_alu_pkg::OP_ADD ||
		opcode == bcd_alu_pkg::OP_SUB || opcode == bcd_alu_pkg::OP_MUL ||
		(opcode == bcd_alu_pkg::OP_DIV && mb != '0));

	bcd_alu_core #(.NUM_DIGITS(NUM_DIGITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(cstart), .op(opcode),
		.a(ma), .b(mb), .done(done), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wait_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (start) begin
				a_less <= ma < mb;
				a_equal <= ma == mb;
				a_greater <= ma > mb;
				err_q <= bad | (opcode == bcd_alu_pkg::OP_DIV && mb == '0);
				if (cstart) begin
					busy_q <= 1'b1;
					wait_q <= 1'b1;
				end else begin
					value_out <= '0;
					error_flag <= bad | (opcode == bcd_alu_pkg::OP_DIV && mb == '0);
					out_valid <= 1'b1;
				end
			end
			if (wait_q && done) begin
				wait_q <= 1'b0;
				busy_q <= 1'b0;
				value_out <= 64'(res);
				error_flag <= err_q;
				out_valid <= 1'b1;
			end
		end
	end
endmodule

// ===== hdl/bcd_alu_core.sv =====
// core: digit-serial sequencer for add, subtract, multiply and divide
module bcd_alu_core #(
	parameter int NUM_DIGITS = bcd_alu_pkg::NUM_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            op,
	input  logic [4*NUM_DIGITS-1:0] a,
	input  logic [4*NUM_DIGITS-1:0] b,
	output logic                  done,
	output logic [4*NUM_DIGITS-1:0] res
);
	localparam int W = 4*NUM_DIGITS;
	localparam int CW = $clog2(NUM_DIGITS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ADD  = 6'b000010,
		ST_MADD = 6'b000100,
		ST_MSH  = 6'b001000,
		ST_DSUB = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic [W-1:0] x_q;      // addend shifted out / rotating partial remainder
	logic [W-1:0] y_q;      // rotating second operand
	logic [W-1:0] acc_q;    // rotating accumulator
	logic [W-1:0] m_q;      // multiplier or dividend digits, msd first
	logic [W-1:0] q_q;      // quotient
	logic [W-1:0] t_q;      // scratch for trial subtraction
	logic [CW-1:0] dig_q;   // digit position within a pass
	logic [CW-1:0] outer_q; // outer digit counter
	logic [3:0] cnt_q;      // repeats of the current digit
	logic carry_q;
	logic [4:0] sum;
	logic [3:0] ysel;
	logic cin;

	always_comb begin
		ysel = 4'd0;
		cin = 1'b0;
		sum = 5'd0;
		case (state_q)
			ST_ADD: begin
				ysel = (op_q == bcd_alu_pkg::OP_SUB) ? bcd_alu_pkg::dec_nines(y_q[3:0]) :
					y_q[3:0];
				cin = (dig_q == '0) ? (op_q == bcd_alu_pkg::OP_SUB) : carry_q;
				sum = bcd_alu_pkg::dec_add(x_q[3:0], ysel, cin);
			end
			ST_MADD: begin
				cin = (dig_q == '0) ? 1'b0 : carry_q;
				sum = bcd_alu_pkg::dec_add(acc_q[3:0], y_q[3:0], cin);
			end
			ST_DSUB: begin
				cin = (dig_q == '0) ? 1'b1 : carry_q;
				sum = bcd_alu_pkg::dec_add(x_q[3:0], bcd_alu_pkg::dec_nines(y_q[3:0]), cin);
			end
			default: ;
		endcase
	end

	assign done = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					op_q <= op;
					dig_q <= '0;
					outer_q <= '0;
					cnt_q <= '0;
					carry_q <= 1'b0;
					acc_q <= '0;
					q_q <= '0;
					y_q <= b;
					m_q <= a;
					if (op == bcd_alu_pkg::OP_ADD || op == bcd_alu_pkg::OP_SUB) begin
						x_q <= a;
						state_q <= ST_ADD;
					end else if (op == bcd_alu_pkg::OP_MUL) begin
						m_q <= b;
						y_q <= a;
						state_q <= ST_MSH;
					end else begin
						state_q <= ST_DSUB;
						t_q <= '0;
						// shift first dividend digit into remainder
						x_q <= {{(W-4){1'b0}}, a[W-1:W-4]};
						m_q <= {a[W-5:0], 4'd0};
					end
				end
				ST_ADD: begin
					x_q <= {4'd0, x_q[W-1:4]};
					y_q <= {y_q[3:0], y_q[W-1:4]};
					acc_q <= {sum[3:0], acc_q[W-1:4]};
					carry_q <= sum[4];
					dig_q <= dig_q + 1'b1;
					if (dig_q == CW'(NUM_DIGITS-1)) begin
						res <= {sum[3:0], acc_q[W-1:4]};
						state_q <= ST_DONE;
					end
				end
				// horner: acc = acc*10 then add a, digit-of-b times
				ST_MSH: begin
					acc_q <= {acc_q[W-5:0], 4'd0};
					cnt_q <= m_q[W-1:W-4];
					m_q <= {m_q[W-5:0], 4'd0};
					dig_q <= '0;
					if (m_q[W-1:W-4] != 4'd0)
						state_q <= ST_MADD;
					else if (outer_q == CW'(NUM_DIGITS-1)) begin
						res <= {acc_q[W-5:0], 4'd0};
						state_q <= ST_DONE;
					end else
						outer_q <= outer_q + 1'b1;
				end
				ST_MADD: begin
					acc_q <= {sum[3:0], acc_q[W-1:4]};
					y_q <= {y_q[3:0], y_q[W-1:4]};
					carry_q <= sum[4];
					dig_q <= dig_q + 1'b1;
					if (dig_q == CW'(NUM_DIGITS-1)) begin
						dig_q <= '0;
						if (cnt_q == 4'd1) begin
							if (outer_q == CW'(NUM_DIGITS-1)) begin
								res <= {sum[3:0], acc_q[W-1:4]};
								state_q <= ST_DONE;
							end else begin
								outer_q <= outer_q + 1'b1;
								state_q <= ST_MSH;
							end
						end else
							cnt_q <= cnt_q - 1'b1;
					end
				end
				// trial subtract r - b digit-serially; keep on no borrow
				ST_DSUB: begin
					x_q <= {x_q[3:0], x_q[W-1:4]};
					y_q <= {y_q[3:0], y_q[W-1:4]};
					t_q <= {sum[3:0], t_q[W-1:4]};
					carry_q <= sum[4];
					dig_q <= dig_q + 1'b1;
					if (dig_q == CW'(NUM_DIGITS-1)) begin
						dig_q <= '0;
						if (sum[4]) begin
							x_q <= {sum[3:0], t_q[W-1:4]};
							q_q[3:0] <= q_q[3:0] + 4'd1;
						end else if (outer_q == CW'(NUM_DIGITS-1)) begin
							res <= q_q;
							state_q <= ST_DONE;
						end else begin
							outer_q <= outer_q + 1'b1;
							q_q <= {q_q[W-5:0], 4'd0};
							x_q <= {x_q[W-1:4], m_q[W-1:W-4]};
							m_q <= {m_q[W-5:0], 4'd0};
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the decimal alu: random and directed beats checked against a behavioral predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_beat_t;

	typedef struct {
		logic [63:0] value;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        err;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] value_out;
	logic a_less, a_equal, a_greater, error_flag;

	bcd_fixed_width_alu dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	alu_beat_t   pending_beats[$];
	alu_result_t expected_results[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_cycles = 0;
	int          n_errors = 0;
	int          n_results = 0;
	int          n_sent = 0;
	int          n_queued = 0;
	longint      cycle_count = 0;

	function automatic logic [63:0] bcd_to_int(logic [63:0] v);
		logic [63:0] r;
		r = 0;
		for (int i = 15; i >= 0; i--)
			r = r * 10 + v[4*i +: 4];
		return r;
	endfunction

	function automatic logic [63:0] int_to_bcd(logic [63:0] v);
		logic [63:0] r;
		r = 0;
		for (int i = 0; i < 16; i++) begin
			r[4*i +: 4] = 4'(v % 10);
			v = v / 10;
		end
		return r;
	endfunction

	function automatic alu_result_t predict_alu(alu_beat_t t);
		alu_result_t r;
		logic [63:0] x, y, m;
		logic [127:0] prod;
		logic ok;
		m = 64'd10000000000000000;
		r.value = 0;
		r.err = 1'b0;
		r.lt = t.a < t.b;
		r.eq = t.a == t.b;
		r.gt = t.a > t.b;
		ok = 1'b1;
		for (int i = 0; i < 16; i++)
			if (t.a[4*i +: 4] > 9 || t.b[4*i +: 4] > 9) ok = 1'b0;
		if (!ok) begin
			r.err = 1'b1;
		end else begin
			x = bcd_to_int(t.a);
			y = bcd_to_int(t.b);
			case (t.op)
				bcd_alu_pkg::OP_ADD: r.value = int_to_bcd((x + y) % m);
				bcd_alu_pkg::OP_SUB: r.value = int_to_bcd((x + (m - y)) % m);
				bcd_alu_pkg::OP_MUL: begin
					prod = {64'd0, x} * {64'd0, y};
					r.value = int_to_bcd(64'(prod % {64'd0, m}));
				end
				bcd_alu_pkg::OP_DIV: begin
					if (y == 0) r.err = 1'b1;
					else r.value = int_to_bcd(x / y);
				end
				default: r.value = 0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_bcd(int ndig);
		logic [63:0] v;
		v = 0;
		for (int i = 0; i < ndig; i++)
			v[4*i +: 4] = 4'($urandom_range(0, 9));
		return v;
	endfunction

	task automatic queue_beat(logic [2:0] op, logic [63:0] a, logic [63:0] b);
		alu_beat_t t;
		t.op = op;
		t.a = a;
		t.b = b;
		pending_beats.push_back(t);
		n_queued++;
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s at result %0d: got %h want %h", what, n_results, got, want);
		n_errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) begin
					expected_results.push_back(predict_alu('{opcode, operand_a, operand_b}));
					n_sent++;
				end
				if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					alu_beat_t t;
					t = pending_beats.pop_front();
					in_valid <= 1'b1;
					opcode <= t.op;
					operand_a <= t.a;
					operand_b <= t.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected", value_out, 64'd0);
				end else begin
					alu_result_t e;
					e = expected_results.pop_front();
					if (value_out !== e.value) report_mismatch("value", value_out, e.value);
					if (a_less !== e.lt) report_mismatch("less", a_less, e.lt);
					if (a_equal !== e.eq) report_mismatch("equal", a_equal, e.eq);
					if (a_greater !== e.gt) report_mismatch("greater", a_greater, e.gt);
					if (error_flag !== e.err) report_mismatch("error", error_flag, e.err);
				end
				n_results++;
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 10000000) begin
			$display("timeout");
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain;
		while (n_results < n_queued)
			@(posedge clk);
	endtask

	task automatic random_phase(int n);
		int k, nd;
		logic [63:0] a, b;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			nd = (k < 70) ? $urandom_range(1, 4) : $urandom_range(1, 16);
			a = rand_bcd(nd);
			b = rand_bcd($urandom_range(0, 1) ? nd : $urandom_range(1, 16));
			if (k < 8) a = {$urandom(), $urandom()};
			if (k >= 8 && k < 14) b = {$urandom(), $urandom()};
			if (k >= 14 && k < 18) b = 0;
			if (k >= 18 && k < 22) b = a;
			queue_beat(3'($urandom_range(0, 7)), a, b);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed beats
		queue_beat(bcd_alu_pkg::OP_ADD, 64'h9999999999999999, 64'h1);
		queue_beat(bcd_alu_pkg::OP_ADD, 0, 0);
		queue_beat(bcd_alu_pkg::OP_SUB, 0, 1);
		queue_beat(bcd_alu_pkg::OP_SUB, 64'h9999999999999999, 64'h9999999999999999);
		queue_beat(bcd_alu_pkg::OP_MUL, 64'h9999999999999999, 64'h9999999999999999);
		queue_beat(bcd_alu_pkg::OP_MUL, 64'h12345678, 0);
		queue_beat(bcd_alu_pkg::OP_DIV, 64'h9999999999999999, 64'h3);
		queue_beat(bcd_alu_pkg::OP_DIV, 64'h5, 64'h9999999999999999);
		queue_beat(bcd_alu_pkg::OP_DIV, 64'h1234, 0);
		queue_beat(bcd_alu_pkg::OP_CMP, 64'h42, 64'h42);
		queue_beat(bcd_alu_pkg::OP_CMP, 64'h41, 64'h42);
		queue_beat(3'd5, 64'h43, 64'h42);
		queue_beat(3'd7, 64'hFFFFFFFFFFFFFFFF, 0);
		queue_beat(bcd_alu_pkg::OP_ADD, 64'hA, 64'h1);
		queue_beat(bcd_alu_pkg::OP_DIV, 64'h1, 64'hF000000000000000);
		queue_beat(bcd_alu_pkg::OP_SUB, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
		queue_beat(3'd6, 64'h1, 64'h1);
		random_phase(120);
		drain();
		send_idle_pct = 49;
		random_phase(120);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 49;
		random_phase(120);
		drain();
		send_idle_pct = 38;
		recv_stall_pct = 38;
		random_phase(120);
		drain();
		// long receiver hold while the sender keeps offering
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 400;
		random_phase(100);
		drain();
		repeat (4000) @(posedge clk);
		$display("%0d beats sent, %0d results checked over idle, stall and hold phases",
			n_sent, n_results);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
